### sv/cpg_pkg.sv
// ---------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the circle point generator.
// ---------------------------------------------------------------------------
package cpg_pkg;

    localparam int OCTANT_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(OCTANT_DEPTH);
    localparam int CNT_W        = $clog2(OCTANT_DEPTH + 1);
    localparam int FULL_W       = CNT_W + 3;
    localparam int COORD_W      = 10;
    localparam int ENTRY_W      = 2 * COORD_W;
    localparam int IDX_W        = 16;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 4;

    localparam logic [1:0] KIND_BUILD  = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_OCTANT = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0]  center_x;
        logic [DATA_W-1:0]  center_y;
        logic [COORD_W-1:0] radius;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } div_res_t;

endpackage

### sv/cpg_regs.sv
// ---------------------------------------------------------------------------
// cpg_regs
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
module cpg_regs
    import cpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [DATA_W-1:0]  center_x_reg;
    logic [DATA_W-1:0]  center_y_reg;
    logic [COORD_W-1:0] radius_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X: center_x_reg <= pwdata;
                REG_CENTER_Y: center_y_reg <= pwdata;
                REG_RADIUS:   radius_reg   <= pwdata[COORD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = center_x_reg;
            REG_CENTER_Y: prdata = center_y_reg;
            REG_RADIUS:   prdata = {{(DATA_W-COORD_W){1'b0}}, radius_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.radius   = radius_reg;

endmodule

### sv/cpg_div.sv
// ---------------------------------------------------------------------------
// cpg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cpg_div
    import cpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_res_t         res
);

    localparam int STEP_W = $clog2(IDX_W);

    logic [IDX_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quot_reg[IDX_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(IDX_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[IDX_W-2:0], fits};
            rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && divisor != '0 |-> rem_reg < divisor)
        else $error("Divider remainder not below divisor.");

endmodule

### sv/circle_point_generator.sv
// ---------------------------------------------------------------------------
// circle_point_generator
// Midpoint circle octant builder with mirrored full-circle point lookup.
// ---------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; kind selects
// a table build, a full-circle fetch or a raw octant fetch. Each transaction
// yields one result, shown for one cycle with done high; the receiver cannot
// stall it, so it must take the result in that cycle.
// The user must write center and radius over the APB port only while the
// block is idle; the block itself does not enforce it. Per kind:
//   build: one octant point per cycle, limited by the table write port.
//   full fetch: the 16-step divider splits the index into octant and
//          position, then one table read.
//   raw fetch: one table read. A fetch that fails a check shows done in
//          the cycle after it is accepted.
// A new transaction can be accepted in the cycle that done is high.
// Reset clears the state, done flag and point count, so fetches report the
// table as not built until the first build. The table itself is not cleared.
// ---------------------------------------------------------------------------
module circle_point_generator
    import cpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      start,
    input  logic [1:0]                kind,
    input  logic [IDX_W-1:0]          element_index,
    output logic                      busy,
    output logic                      done,
    output logic signed [DATA_W-1:0]  point_x,
    output logic signed [DATA_W-1:0]  point_y,
    output logic [CNT_W-1:0]          octant_count,
    output logic [FULL_W-1:0]         full_count,
    output logic [1:0]                status
);

    localparam int XY_W  = COORD_W + 2;
    localparam int ERR_W = COORD_W + 4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    cfg_t     cfg;
    div_res_t div_res;

    state_t                   state_reg, state_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     full_reg, full_next;
    logic [2:0]               oct_reg, oct_next;
    logic                     done_reg, done_next;
    logic [DATA_W-1:0]        px_reg, px_next;
    logic [DATA_W-1:0]        py_reg, py_next;
    logic [1:0]               status_reg, status_next;

    logic [ENTRY_W-1:0]       oct_mem [OCTANT_DEPTH];
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]       wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     div_start;

    logic signed [XY_W-1:0]   y_step;
    logic signed [ERR_W-1:0]  err_mid;
    logic signed [XY_W-1:0]   x_step;
    logic signed [ERR_W-1:0]  err_step;
    logic                     build_go;
    logic [CNT_W-1:0]         pos;
    logic [DATA_W-1:0]        sx;
    logic [DATA_W-1:0]        sy;
    logic [DATA_W-1:0]        mx;
    logic [DATA_W-1:0]        my;

    cpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (element_index),
        .divisor  (cnt_reg),
        .res      (div_res)
    );

    // One midpoint step of the error term.
    always_comb
    begin
        if (err_reg <= 0)
        begin
            y_step  = y_reg + 2'sd1;
            err_mid = err_reg + ERR_W'({y_reg + 2'sd1, 1'b1});
        end
        else
        begin
            y_step  = y_reg;
            err_mid = err_reg;
        end
        if (err_mid > 0)
        begin
            x_step   = x_reg - 2'sd1;
            err_step = err_mid - ERR_W'({x_reg - 2'sd1, 1'b1});
        end
        else
        begin
            x_step   = x_reg;
            err_step = err_mid;
        end
    end

    assign build_go = (x_reg >= y_reg) && (n_reg < CNT_W'(OCTANT_DEPTH));
    assign wr_en    = (state_reg == ST_BUILD) && build_go;
    assign wr_addr  = n_reg[ADDR_W-1:0];
    assign wr_data  = {x_reg[COORD_W-1:0], y_reg[COORD_W-1:0]};

    assign pos = div_res.quot[0] ? (cnt_reg - div_res.rem - 1'b1) : div_res.rem;

    assign sx = {{(DATA_W-COORD_W){1'b0}}, rd_data_reg[ENTRY_W-1:COORD_W]};
    assign sy = {{(DATA_W-COORD_W){1'b0}}, rd_data_reg[COORD_W-1:0]};

    always_comb
    begin
        case (oct_reg)
            3'd0:    begin mx = sx;      my = sy;      end
            3'd1:    begin mx = sy;      my = sx;      end
            3'd2:    begin mx = '0 - sy; my = sx;      end
            3'd3:    begin mx = '0 - sx; my = sy;      end
            3'd4:    begin mx = '0 - sx; my = '0 - sy; end
            3'd5:    begin mx = '0 - sy; my = '0 - sx; end
            3'd6:    begin mx = sy;      my = '0 - sx; end
            default: begin mx = sx;      my = '0 - sy; end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        err_next    = err_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        full_next   = full_reg;
        oct_next    = oct_reg;
        done_next   = 1'b0;
        px_next     = px_reg;
        py_next     = py_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = element_index[ADDR_W-1:0];
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_BUILD)
                    begin
                        x_next     = XY_W'(cfg.radius);
                        y_next     = '0;
                        err_next   = '0;
                        n_next     = '0;
                        state_next = ST_BUILD;
                    end
                    else if (cnt_reg == '0)
                    begin
                        px_next     = '0;
                        py_next     = '0;
                        status_next = STATUS_NOT_BUILT;
                        done_next   = 1'b1;
                    end
                    else if (kind == KIND_FULL)
                    begin
                        div_start  = 1'b1;
                        full_next  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (element_index >= IDX_W'(cnt_reg))
                    begin
                        px_next     = '0;
                        py_next     = '0;
                        status_next = STATUS_RANGE;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        full_next  = 1'b0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_BUILD:
            begin
                if (build_go)
                begin
                    n_next   = n_reg + 1'b1;
                    x_next   = x_step;
                    y_next   = y_step;
                    err_next = err_step;
                end
                else
                begin
                    cnt_next    = n_reg;
                    px_next     = '0;
                    py_next     = '0;
                    status_next = STATUS_OK;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rd_addr = pos[ADDR_W-1:0];
                if (div_res.done)
                begin
                    rd_en      = 1'b1;
                    oct_next   = div_res.quot[2:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (full_reg)
                begin
                    px_next = mx + cfg.center_x;
                    py_next = my + cfg.center_y;
                end
                else
                begin
                    px_next = sx;
                    py_next = sy;
                end
                status_next = STATUS_OK;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        err_reg    <= err_next;
        n_reg      <= n_next;
        full_reg   <= full_next;
        oct_reg    <= oct_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            oct_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= oct_mem[rd_addr];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign status       = status_reg;
    assign octant_count = cnt_reg;
    assign full_count   = {cnt_reg, 3'b000};

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("Accepted transaction neither finished nor kept the block busy.");

    a_not_built_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_NOT_BUILT |-> octant_count == '0 && point_x == '0)
        else $error("Not-built status with a nonzero count or point.");

    a_build_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BUILD |-> n_reg <= CNT_W'(OCTANT_DEPTH))
        else $error("Build point count exceeded the table depth.");

endmodule
